// ===== rtl/core/cmhr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmhr_pkg
// Shared widths, constants and angle helpers for the minimum-hop router.
// ----------------------------------------------------------------------------
package cmhr_pkg;

    localparam int ANGLE_W = 25;
    localparam int HOP_W   = 9;
    localparam int TOT_W   = 10;
    localparam int DIR_W   = 2;
    localparam int IDX_W   = 2;

    // A full turn of 360 degrees in Q16, and the one-degree spacing floor.
    localparam logic [ANGLE_W-1:0] FULL_TURN   = 25'd23592960;
    localparam logic [ANGLE_W-1:0] MIN_SPACING = 25'd65536;

    // A full turn is 45 * 2^19, so a product is reduced modulo a turn by
    // taking its upper bits modulo 45 and keeping the lower 19 bits.
    localparam int TURN_SHIFT = 19;
    localparam int TURN_ODD   = 45;
    localparam int RECIP_W    = 16;
    localparam int RECIP_ODD  = 1456;

    // Register indices.
    localparam logic [IDX_W-1:0] REG_PLANE_SPACING  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLOT_SPACING   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PHASING_OFFSET = 2'd2;

    // Route directions.
    localparam logic [DIR_W-1:0] DIR_WEST_UP   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_WEST_DOWN = 2'd1;
    localparam logic [DIR_W-1:0] DIR_EAST_UP   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_EAST_DOWN = 2'd3;

    localparam logic [ANGLE_W-1:0] REG_SPACING_RST = 25'd1966080;

    // Reduce a value below two turns into [0, 360).
    function automatic logic [ANGLE_W-1:0] wrap_turn(input logic [ANGLE_W:0] a);
        logic [ANGLE_W:0] t;
        t = {1'b0, FULL_TURN};
        if (a >= t) begin
            return ANGLE_W'(a - t);
        end
        return ANGLE_W'(a);
    endfunction

    // (a - b) modulo a turn, both operands already reduced.
    function automatic logic [ANGLE_W-1:0] sub_turn(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
        if (a >= b) begin
            return a - b;
        end
        return ANGLE_W'({1'b0, a} + {1'b0, FULL_TURN} - {1'b0, b});
    endfunction

    function automatic logic [ANGLE_W-1:0] eff_spacing(input logic [ANGLE_W-1:0] s);
        return (s < MIN_SPACING) ? MIN_SPACING : s;
    endfunction

endpackage

// ===== rtl/core/constellation_min_hop_router.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constellation_min_hop_router
// Minimum-hop direction finder for a Walker-delta satellite constellation.
// ----------------------------------------------------------------------------
// The router accepts one query transaction per clock cycle while the result
// side is not stalled and returns one result transaction for each, in order.
// Each query passes through a chain of two pipelined dividers (plane hops,
// then in-plane hops) with the phasing product between them. The
// whole pipeline advances together whenever the output register is empty or
// its transaction is being taken, so a stall on the result side holds every
// stage and nothing is lost or repeated. Angles are unsigned Q16 degrees and
// are reduced modulo 360 degrees; spacings below one degree act as one
// degree. The configuration registers may only be written while the router
// holds no transaction.
module constellation_min_hop_router
    import cmhr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_wr_index,
    input  logic [ANGLE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ANGLE_W-1:0] s_src_phase,
    input  logic [ANGLE_W-1:0] s_src_plane_angle,
    input  logic [ANGLE_W-1:0] s_dst_phase,
    input  logic [ANGLE_W-1:0] s_dst_plane_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TOT_W-1:0]   m_total_hops,
    output logic [DIR_W-1:0]   m_direction,
    output logic [HOP_W-1:0]   m_horizontal_hops,
    output logic [HOP_W-1:0]   m_vertical_hops,
    output logic [TOT_W-1:0]   m_west_up_hops,
    output logic [TOT_W-1:0]   m_west_down_hops,
    output logic [TOT_W-1:0]   m_east_up_hops,
    output logic [TOT_W-1:0]   m_east_down_hops
);

    localparam int DIV_LAT  = HOP_W + 1;
    localparam int MOD_LAT  = 4;
    localparam int PIPE_LEN = 2 + DIV_LAT + MOD_LAT + 2 + DIV_LAT + 2;

    // ------------------------------------------------------------------
    // Configuration registers, with the spacing floor applied in a register
    // of its own so that it stays off the datapath.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] plane_spacing_reg;
    logic [ANGLE_W-1:0] slot_spacing_reg;
    logic [ANGLE_W-1:0] phasing_offset_reg;
    logic [ANGLE_W-1:0] eff_plane_reg;
    logic [ANGLE_W-1:0] eff_slot_reg;
    logic [ANGLE_W-1:0] eff_phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_spacing_reg  <= REG_SPACING_RST;
            slot_spacing_reg   <= REG_SPACING_RST;
            phasing_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PLANE_SPACING:  plane_spacing_reg  <= cfg_wr_data;
                REG_SLOT_SPACING:   slot_spacing_reg   <= cfg_wr_data;
                REG_PHASING_OFFSET: phasing_offset_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        eff_plane_reg <= eff_spacing(plane_spacing_reg);
        eff_slot_reg  <= eff_spacing(slot_spacing_reg);
        eff_phase_reg <= wrap_turn({1'b0, phasing_offset_reg});
    end

    // ------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, all stages share one enable.
    // ------------------------------------------------------------------
    logic [PIPE_LEN-1:0] vld_reg;
    logic                en;

    assign en      = !vld_reg[PIPE_LEN-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_valid};
        end
    end

    // Stage 0: reduce the inputs into a single turn.
    logic [ANGLE_W-1:0] us_reg, rs_reg, ud_reg, rd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            us_reg <= wrap_turn({1'b0, s_src_phase});
            rs_reg <= wrap_turn({1'b0, s_src_plane_angle});
            ud_reg <= wrap_turn({1'b0, s_dst_phase});
            rd_reg <= wrap_turn({1'b0, s_dst_plane_angle});
        end
    end

    // Stage 1: plane angle distances both ways round, and the phase distance.
    logic [ANGLE_W-1:0] l_east_reg, l_west_reg, pdiff_reg;
    logic [ANGLE_W-1:0] l_east;

    assign l_east = sub_turn(rd_reg, rs_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            l_east_reg <= l_east;
            l_west_reg <= sub_turn('0, l_east);
            pdiff_reg  <= sub_turn(ud_reg, us_reg);
        end
    end

    // Inter-plane hop counts.
    logic [HOP_W-1:0] h_west, h_east;

    cmhr_div u_div_h_west (
        .aclk(aclk), .en(en), .num(l_west_reg), .den(eff_plane_reg), .quo(h_west)
    );
    cmhr_div u_div_h_east (
        .aclk(aclk), .en(en), .num(l_east_reg), .den(eff_plane_reg), .quo(h_east)
    );

    // Phasing picked up along the plane hops, modulo a turn.
    logic [ANGLE_W-1:0] mod_west, mod_east;

    cmhr_mulmod u_mod_west (
        .aclk(aclk), .en(en), .hops(h_west), .offset(eff_phase_reg), .prod_mod(mod_west)
    );
    cmhr_mulmod u_mod_east (
        .aclk(aclk), .en(en), .hops(h_east), .offset(eff_phase_reg), .prod_mod(mod_east)
    );

    // The phase distance waits for the phasing correction.
    logic [ANGLE_W-1:0] pdiff_dly;

    cmhr_delay #(.WIDTH(ANGLE_W), .DEPTH(DIV_LAT + MOD_LAT)) u_dly_pdiff (
        .aclk(aclk), .en(en), .din(pdiff_reg), .dout(pdiff_dly)
    );

    // Corrected in-plane distances, then their complements for going down.
    logic [ANGLE_W-1:0] d_west_reg, d_east_reg;
    logic [ANGLE_W-1:0] up_west_reg, up_east_reg, dn_west_reg, dn_east_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_east_reg  <= sub_turn(pdiff_dly, mod_east);
            d_west_reg  <= wrap_turn({1'b0, pdiff_dly} + {1'b0, mod_west});
            up_west_reg <= d_west_reg;
            up_east_reg <= d_east_reg;
            dn_west_reg <= FULL_TURN - d_west_reg;
            dn_east_reg <= FULL_TURN - d_east_reg;
        end
    end

    // In-plane hop counts.
    logic [HOP_W-1:0] v_up_w, v_up_e, v_dn_w, v_dn_e;

    cmhr_div u_div_up_west (
        .aclk(aclk), .en(en), .num(up_west_reg), .den(eff_slot_reg), .quo(v_up_w)
    );
    cmhr_div u_div_up_east (
        .aclk(aclk), .en(en), .num(up_east_reg), .den(eff_slot_reg), .quo(v_up_e)
    );
    cmhr_div u_div_dn_west (
        .aclk(aclk), .en(en), .num(dn_west_reg), .den(eff_slot_reg), .quo(v_dn_w)
    );
    cmhr_div u_div_dn_east (
        .aclk(aclk), .en(en), .num(dn_east_reg), .den(eff_slot_reg), .quo(v_dn_e)
    );

    // The plane hop counts wait for the in-plane counts.
    logic [2*HOP_W-1:0] h_dly;

    cmhr_delay #(.WIDTH(2 * HOP_W), .DEPTH(MOD_LAT + 2 + DIV_LAT)) u_dly_h (
        .aclk(aclk), .en(en), .din({h_west, h_east}), .dout(h_dly)
    );

    // Route totals.
    logic [TOT_W-1:0] tot_reg [4];
    logic [HOP_W-1:0] hor_reg [4];
    logic [HOP_W-1:0] ver_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg[0] <= TOT_W'(h_dly[2*HOP_W-1:HOP_W]) + TOT_W'(v_up_w);
            tot_reg[1] <= TOT_W'(h_dly[2*HOP_W-1:HOP_W]) + TOT_W'(v_dn_w);
            tot_reg[2] <= TOT_W'(h_dly[HOP_W-1:0]) + TOT_W'(v_up_e);
            tot_reg[3] <= TOT_W'(h_dly[HOP_W-1:0]) + TOT_W'(v_dn_e);
            hor_reg[0] <= h_dly[2*HOP_W-1:HOP_W];
            hor_reg[1] <= h_dly[2*HOP_W-1:HOP_W];
            hor_reg[2] <= h_dly[HOP_W-1:0];
            hor_reg[3] <= h_dly[HOP_W-1:0];
            ver_reg[0] <= v_up_w;
            ver_reg[1] <= v_dn_w;
            ver_reg[2] <= v_up_e;
            ver_reg[3] <= v_dn_e;
        end
    end

    // Pick the smallest total; only a strictly smaller total displaces an
    // earlier direction, so ties keep the earlier one.
    logic [DIR_W-1:0] best;

    always_comb begin
        best = DIR_WEST_UP;
        if (tot_reg[DIR_WEST_DOWN] < tot_reg[best]) begin
            best = DIR_WEST_DOWN;
        end
        if (tot_reg[DIR_EAST_UP] < tot_reg[best]) begin
            best = DIR_EAST_UP;
        end
        if (tot_reg[DIR_EAST_DOWN] < tot_reg[best]) begin
            best = DIR_EAST_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_total_hops      <= tot_reg[best];
            m_direction       <= best;
            m_horizontal_hops <= hor_reg[best];
            m_vertical_hops   <= ver_reg[best];
            m_west_up_hops    <= tot_reg[DIR_WEST_UP];
            m_west_down_hops  <= tot_reg[DIR_WEST_DOWN];
            m_east_up_hops    <= tot_reg[DIR_EAST_UP];
            m_east_down_hops  <= tot_reg[DIR_EAST_DOWN];
        end
    end

endmodule

// ===== rtl/core/cmhr_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmhr_delay
// Stallable shift line that keeps side data level with the pipeline.
// ----------------------------------------------------------------------------
module cmhr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== rtl/core/cmhr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmhr_div
// Pipelined restoring divider giving round-half-up of num / den.
// ----------------------------------------------------------------------------
module cmhr_div
    import cmhr_pkg::*;
#(
    parameter int NUM_W = ANGLE_W,
    parameter int QUO_W = HOP_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int R_W = NUM_W + 2;
    localparam int D_W = NUM_W + 1;
    localparam int T_W = D_W + QUO_W;

    // Rounding is folded in as floor((2*num + den) / (2*den)).
    logic [R_W-1:0]   n_reg;
    logic [D_W-1:0]   d_reg;
    logic [R_W-1:0]   rem_reg [QUO_W-1];
    logic [D_W-1:0]   dd_reg  [QUO_W-1];
    logic [QUO_W-1:0] q_reg   [QUO_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= R_W'({num, 1'b0}) + R_W'(den);
            d_reg <= {den, 1'b0};
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic [R_W-1:0]   r_in;
        logic [D_W-1:0]   d_in;
        logic [QUO_W-1:0] q_in;
        logic [T_W-1:0]   trial;
        logic [T_W-1:0]   rext;
        logic             take;

        if (j == 0) begin : g_first
            assign r_in = n_reg;
            assign d_in = d_reg;
            assign q_in = '0;
        end else begin : g_next
            assign r_in = rem_reg[j-1];
            assign d_in = dd_reg[j-1];
            assign q_in = q_reg[j-1];
        end

        assign trial = T_W'(d_in) << (QUO_W - 1 - j);
        assign rext  = T_W'(r_in);
        assign take  = (rext >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j] <= take ? (q_in | (QUO_W'(1) << (QUO_W - 1 - j))) : q_in;
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? R_W'(rext - trial) : r_in;
                    dd_reg[j]  <= d_in;
                end
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

// ===== rtl/core/cmhr_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmhr_mulmod
// Four-stage unit giving (hops * offset) modulo a full turn.
// ----------------------------------------------------------------------------
module cmhr_mulmod
    import cmhr_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [HOP_W-1:0]   hops,
    input  logic [ANGLE_W-1:0] offset,
    output logic [ANGLE_W-1:0] prod_mod
);

    localparam int P_W  = HOP_W + ANGLE_W;
    localparam int X_W  = P_W - TURN_SHIFT;
    localparam int Q_W  = X_W + 11 - RECIP_W;
    localparam int R_W  = 7;
    localparam int RC_W = ANGLE_W - TURN_SHIFT;

    logic [P_W-1:0]        prod_reg;
    logic [X_W-1:0]        x_reg;
    logic [Q_W-1:0]        qe_reg;
    logic [TURN_SHIFT-1:0] low_reg;
    logic [TURN_SHIFT-1:0] low2_reg;
    logic [R_W-1:0]        r_reg;
    logic [ANGLE_W-1:0]    mod_reg;

    logic [X_W+10:0] x_scaled;
    logic [X_W-1:0]  x_diff;
    logic [R_W-1:0]  r_fix;

    // The reciprocal underestimates, so the remainder lands below twice 45.
    assign x_scaled = (X_W+11)'(prod_reg[P_W-1:TURN_SHIFT]) * (X_W+11)'(RECIP_ODD);
    assign x_diff   = x_reg - X_W'(qe_reg * X_W'(TURN_ODD));
    assign r_fix    = (r_reg >= R_W'(TURN_ODD)) ? r_reg - R_W'(TURN_ODD) : r_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= P_W'(hops) * P_W'(offset);
            x_reg    <= prod_reg[P_W-1:TURN_SHIFT];
            low_reg  <= prod_reg[TURN_SHIFT-1:0];
            qe_reg   <= x_scaled[X_W+10:RECIP_W];
            r_reg    <= x_diff[R_W-1:0];
            low2_reg <= low_reg;
            mod_reg  <= {r_fix[RC_W-1:0], low2_reg};
        end
    end

    assign prod_mod = mod_reg;

endmodule

// ===== rtl/core/cmhr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmhr_checker
// Port-level checks on the result channel of the minimum-hop router.
// ----------------------------------------------------------------------------
module cmhr_checker
    import cmhr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [TOT_W-1:0] m_total_hops,
    input logic [DIR_W-1:0] m_direction,
    input logic [HOP_W-1:0] m_horizontal_hops,
    input logic [HOP_W-1:0] m_vertical_hops,
    input logic [TOT_W-1:0] m_west_up_hops,
    input logic [TOT_W-1:0] m_west_down_hops,
    input logic [TOT_W-1:0] m_east_up_hops,
    input logic [TOT_W-1:0] m_east_down_hops
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_hops) && $stable(m_direction))
        else $error("result transaction changed while stalled");

    a_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_total_hops <= m_west_up_hops && m_total_hops <= m_west_down_hops &&
                    m_total_hops <= m_east_up_hops && m_total_hops <= m_east_down_hops)
        else $error("total is not the minimum of the routes");

    a_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_total_hops == TOT_W'(m_horizontal_hops) + TOT_W'(m_vertical_hops))
        else $error("total differs from its hop split");

    a_tie: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_west_up_hops == m_total_hops |-> m_direction == DIR_WEST_UP)
        else $error("tie not resolved to west-up");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind constellation_min_hop_router cmhr_checker u_cmhr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_total_hops      (m_total_hops),
    .m_direction       (m_direction),
    .m_horizontal_hops (m_horizontal_hops),
    .m_vertical_hops   (m_vertical_hops),
    .m_west_up_hops    (m_west_up_hops),
    .m_west_down_hops  (m_west_down_hops),
    .m_east_up_hops    (m_east_up_hops),
    .m_east_down_hops  (m_east_down_hops)
);
